/* rtl/q4k_pkg.sv */
// q4k_pkg: shared types, constants and helpers for the q4_k block dequantizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package q4k_pkg;

    localparam int BLOCK_BYTES = 144;
    localparam int HDR_BYTES   = 16;
    localparam int BLOCK_ELEMS = 256;
    localparam int CFG_W       = 17;
    localparam logic [CFG_W-1:0] ROW_LEN_RESET = 17'd256;

    // magnitude width after aligning both products to a 2^-24 lsb
    localparam int MAG_W = 52;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_begin;
    } t_in_item;

    typedef struct packed {
        logic [15:0] element_index;
        logic [31:0] low_value;
        logic        low_valid;
        logic [31:0] high_value;
        logic        high_valid;
        logic        row_last;
    } t_out_item;

    // decoded fp16: value = sign * man * 2^(sh - 24)
    typedef struct packed {
        logic        sign;
        logic [10:0] man;
        logic [4:0]  sh;
    } t_half;

    typedef struct packed {
        t_half       d;
        t_half       dm;
        logic [5:0]  sc_lo;
        logic [5:0]  mn_lo;
        logic [3:0]  q_lo;
        logic [5:0]  sc_hi;
        logic [5:0]  mn_hi;
        logic [3:0]  q_hi;
        logic [15:0] element_index;
        logic        low_valid;
        logic        high_valid;
        logic        row_last;
    } t_job;

    // exponent 31 stays finite, both zeros come out positive
    function automatic t_half half_decode(input logic [15:0] h);
        t_half r;
        r.sign = h[15] & (h[14:0] != 15'd0);
        if (h[14:10] == 5'd0) begin
            r.man = {1'b0, h[9:0]};
            r.sh  = 5'd0;
        end else begin
            r.man = {1'b1, h[9:0]};
            r.sh  = h[14:10] - 5'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/q4k_fifo.sv */
// q4k_fifo: small register queue with full/empty flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module q4k_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

/* rtl/q4k_front.sv */
// q4k_front: byte position tracking, header capture and job building
// depends on q4k_pkg
`timescale 1ns / 1ps
`default_nettype none
module q4k_front
    import q4k_pkg::*;
#(
    parameter int MAX_ROW_ELEMENTS = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_accept,
    input  wire t_in_item         i_item,
    output logic                  o_job_push,
    output t_job                  o_job
);
    localparam int MAX_BLK = (MAX_ROW_ELEMENTS + BLOCK_ELEMS - 1) / BLOCK_ELEMS;
    localparam int BC_W    = (MAX_BLK > 1) ? $clog2(MAX_BLK) : 1;
    localparam int IDX_W   = $clog2(MAX_ROW_ELEMENTS);
    localparam int LEN_W   = IDX_W + 1;
    localparam int CMP_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic [CFG_W-1:0] r_row_length;
    logic [15:0]      r_scale, r_mscale;
    logic [7:0]       r_sub [12];
    logic [7:0]       r_pos, n_pos;
    logic [BC_W-1:0]  r_blk, n_blk;

    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] len, nblk, nblk_raw;
    logic [7:0]       pos;
    logic [BC_W-1:0]  blkc, blk;
    logic             last;
    logic [6:0]       k;
    logic [1:0]       g;
    logic [5:0]       sc_all [8];
    logic [5:0]       mn_all [8];
    logic [LEN_W-1:0] lo_idx, hi_idx;

    always_comb begin
        len_ext  = CMP_W'(r_row_length);
        if (len_ext > CMP_W'(MAX_ROW_ELEMENTS)) begin
            len_ext = CMP_W'(MAX_ROW_ELEMENTS);
        end
        len      = LEN_W'(len_ext);
        nblk_raw = (len + LEN_W'(BLOCK_ELEMS - 1)) >> 8;
        nblk     = (nblk_raw == '0) ? LEN_W'(1) : nblk_raw;

        pos  = i_item.row_begin ? 8'd0 : r_pos;
        blkc = i_item.row_begin ? '0 : r_blk;
        last = 1'b0;
        n_pos = pos + 8'd1;
        n_blk = blkc;
        if (pos >= 8'(BLOCK_BYTES - 1)) begin
            last  = (LEN_W'(blkc) + LEN_W'(1) >= nblk);
            n_pos = 8'd0;
            n_blk = last ? '0 : blkc + 1'b1;
        end
        blk = last ? BC_W'(nblk - LEN_W'(1)) : blkc;

        k = 7'(pos - 8'(HDR_BYTES));
        g = k[6:5];
        lo_idx = LEN_W'({blk, g, 1'b0, k[4:0]});
        hi_idx = lo_idx + LEN_W'(32);

        // sub-scale unpacking, pairs 0..3 plain, 4..7 split over high bits
        for (int j = 0; j < 4; j++) begin
            sc_all[j]   = r_sub[j][5:0];
            mn_all[j]   = r_sub[j+4][5:0];
            sc_all[j+4] = {r_sub[j][7:6], r_sub[j+8][3:0]};
            mn_all[j+4] = {r_sub[j+4][7:6], r_sub[j+8][7:4]};
        end

        o_job.d             = half_decode(r_scale);
        o_job.dm            = half_decode(r_mscale);
        o_job.sc_lo         = sc_all[{g, 1'b0}];
        o_job.mn_lo         = mn_all[{g, 1'b0}];
        o_job.sc_hi         = sc_all[{g, 1'b1}];
        o_job.mn_hi         = mn_all[{g, 1'b1}];
        o_job.q_lo          = i_item.data_byte[3:0];
        o_job.q_hi          = i_item.data_byte[7:4];
        o_job.element_index = 16'(lo_idx);
        o_job.low_valid     = (lo_idx < len);
        o_job.high_valid    = (hi_idx < len);
        o_job.row_last      = last;
        o_job_push          = i_accept & (pos >= 8'(HDR_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_RESET;
            r_scale      <= '0;
            r_mscale     <= '0;
            r_pos        <= '0;
            r_blk        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_length <= i_cfg_data;
            end
            if (i_accept) begin
                r_pos <= n_pos;
                r_blk <= n_blk;
                case (pos)
                    8'd0:    r_scale[7:0]   <= i_item.data_byte;
                    8'd1:    r_scale[15:8]  <= i_item.data_byte;
                    8'd2:    r_mscale[7:0]  <= i_item.data_byte;
                    8'd3:    r_mscale[15:8] <= i_item.data_byte;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && pos >= 8'd4 && pos < 8'(HDR_BYTES)) begin
            r_sub[4'(pos - 8'd4)] <= i_item.data_byte;
        end
    end
endmodule
`default_nettype wire

/* rtl/q4k_back.sv */
// q4k_back: pipelined fp32 evaluation of both nibbles of a job
// depends on q4k_pkg
`timescale 1ns / 1ps
`default_nettype none
module q4k_back
    import q4k_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_out_full,
    output logic      o_item_push,
    output t_out_item o_item
);
    typedef struct packed {
        logic [15:0] element_index;
        logic        low_valid;
        logic        high_valid;
        logic        row_last;
    } t_meta;

    logic        adv;
    logic        r_v1, r_v2, r_v3, r_v4;
    t_meta       r_m1, r_m2, r_m3, r_m4;

    logic [16:0] r_a1 [2];
    logic [16:0] r_b1 [2];
    logic [3:0]  r_q1 [2];
    logic        r_sp1, r_sb1;
    logic [4:0]  r_shp1, r_shb1;

    logic [20:0] r_p2 [2];
    logic [16:0] r_b2 [2];
    logic        r_sp2, r_sb2;
    logic [4:0]  r_shp2, r_shb2;

    logic [MAG_W:0]   r_diff3 [2];
    logic             r_zs3   [2];
    logic [MAG_W-1:0] r_mag4  [2];
    logic [5:0]       r_e4    [2];
    logic             r_s4    [2];
    logic             r_zs4   [2];

    logic [5:0]       sc [2];
    logic [5:0]       mn [2];
    logic [MAG_W:0]   dabs [2];
    logic [5:0]       lz [2];
    logic [MAG_W-1:0] norm;
    logic             rnd;
    logic [30:0]      body;
    logic [31:0]      res [2];

    assign adv       = ~i_out_full;
    assign o_job_pop = adv & i_job_valid;

    always_comb begin
        sc[0] = i_job.sc_lo;
        sc[1] = i_job.sc_hi;
        mn[0] = i_job.mn_lo;
        mn[1] = i_job.mn_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            dabs[i] = r_diff3[i][MAG_W] ? -r_diff3[i] : r_diff3[i];
            lz[i] = 6'd0;
            for (int b = 0; b < MAG_W; b++) begin
                if (dabs[i][b]) begin
                    lz[i] = 6'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1: scale times sub-scale, min times sub-min
            r_m1   <= '{i_job.element_index, i_job.low_valid, i_job.high_valid,
                        i_job.row_last};
            r_sp1  <= i_job.d.sign;
            r_sb1  <= i_job.dm.sign;
            r_shp1 <= i_job.d.sh;
            r_shb1 <= i_job.dm.sh;
            r_q1[0] <= i_job.q_lo;
            r_q1[1] <= i_job.q_hi;
            for (int i = 0; i < 2; i++) begin
                r_a1[i] <= 17'(i_job.d.man) * 17'(sc[i]);
                r_b1[i] <= 17'(i_job.dm.man) * 17'(mn[i]);
            end
            // stage 2: times the nibble
            r_m2   <= r_m1;
            r_sp2  <= r_sp1;
            r_sb2  <= r_sb1;
            r_shp2 <= r_shp1;
            r_shb2 <= r_shb1;
            for (int i = 0; i < 2; i++) begin
                r_p2[i] <= 21'(r_a1[i]) * 21'(r_q1[i]);
                r_b2[i] <= r_b1[i];
            end
            // stage 3: align to a common lsb and subtract exactly
            r_m3 <= r_m2;
            for (int i = 0; i < 2; i++) begin
                r_diff3[i] <= r_sp2 ? ((-((MAG_W+1)'(r_p2[i]) << r_shp2))
                                       - (r_sb2 ? -((MAG_W+1)'(r_b2[i]) << r_shb2)
                                                : ((MAG_W+1)'(r_b2[i]) << r_shb2)))
                                    : (((MAG_W+1)'(r_p2[i]) << r_shp2)
                                       - (r_sb2 ? -((MAG_W+1)'(r_b2[i]) << r_shb2)
                                                : ((MAG_W+1)'(r_b2[i]) << r_shb2)));
                r_zs3[i] <= (r_p2[i] == '0) && (r_b2[i] == '0) && r_sp2 && !r_sb2;
            end
            // stage 4: magnitude and leading one
            r_m4 <= r_m3;
            for (int i = 0; i < 2; i++) begin
                r_mag4[i] <= MAG_W'(dabs[i]);
                r_s4[i]   <= r_diff3[i][MAG_W];
                r_e4[i]   <= lz[i];
                r_zs4[i]  <= r_zs3[i];
            end
        end
    end

    // final stage: normalize, round to nearest even, pack
    always_comb begin
        norm = '0;
        rnd  = 1'b0;
        body = '0;
        for (int i = 0; i < 2; i++) begin
            norm = r_mag4[i] << (6'(MAG_W - 1) - r_e4[i]);
            rnd  = norm[MAG_W-25] & ((|norm[MAG_W-26:0]) | norm[MAG_W-24]);
            body = {8'(r_e4[i]) + 8'd103, norm[MAG_W-2:MAG_W-24]} + 31'(rnd);
            res[i] = (r_mag4[i] == '0) ? {r_zs4[i], 31'd0} : {r_s4[i], body};
        end
        o_item.element_index = r_m4.element_index;
        o_item.low_value     = res[0];
        o_item.low_valid     = r_m4.low_valid;
        o_item.high_value    = res[1];
        o_item.high_valid    = r_m4.high_valid;
        o_item.row_last      = r_m4.row_last;
        o_item_push          = adv & r_v4;
    end
endmodule
`default_nettype wire

/* rtl/q4k_block_dequantizer.sv */
// q4k_block_dequantizer: top level, q4_k super-block stream to fp32 pairs
// depends on q4k_pkg, q4k_front, q4k_back, q4k_fifo
//
// usage: push the quantized row one byte per item on i_in while o_full is
// low; set row_begin on the first byte of a row. each 144-byte super-block
// starts with a 16-byte header (fp16 scale, fp16 min scale, twelve packed
// sub-scale bytes) that gives no result, then 128 nibble bytes that each
// give one result item with two fp32 values and their valid flags.
// results wait in an output queue; while o_empty is low the oldest item is
// on o_out and i_pop takes it.
// throughput: one byte per cycle while o_full is low. from byte accept to
// result on o_out an item passes through the job queue, four pipeline
// registers in the back end and the output queue. the user must write
// row_length through i_cfg_we/i_cfg_data only while idle; the block does
// not enforce it. reset: byte position and block count clear, row_length
// returns to 256, both queues empty. when pop is held low the output queue
// fills, the back end freezes, the job queue fills and o_full rises.
`timescale 1ns / 1ps
`default_nettype none
module q4k_block_dequantizer
    import q4k_pkg::*;
#(
    parameter int MAX_ROW_ELEMENTS = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_in_item         i_in,
    output logic                  o_full,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output t_out_item             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    logic      accept, job_push, job_full, job_empty, job_pop;
    logic      out_full, item_push;
    t_job      job_in, job_out;
    t_out_item item;

    assign o_full = job_full;
    assign accept = i_push & ~job_full;

    q4k_front #(.MAX_ROW_ELEMENTS(MAX_ROW_ELEMENTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    q4k_fifo #(.WIDTH($bits(t_job)), .DEPTH(4)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    q4k_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (~job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_item_push (item_push),
        .o_item      (item)
    );

    q4k_fifo #(.WIDTH($bits(t_out_item)), .DEPTH(4)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (item),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_out)
    );
endmodule
`default_nettype wire

/* bench/q4k_block_dequantizer_test.sv */
// q4k_block_dequantizer_test: self-checking bench for the q4_k dequantizer
// streams super-blocks through the byte queue and checks each result item
// against an integer-exact predictor; depends on q4k_pkg and the rtl top
`timescale 1ns / 1ps
module q4k_block_dequantizer_test;
    import q4k_pkg::*;

    localparam int MAX_ELEMS  = 65536;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_PHASES = 9;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_push;
    t_in_item         i_in;
    logic             o_full;
    logic             o_empty;
    logic             i_pop;
    t_out_item        o_out;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    q4k_block_dequantizer #(.MAX_ROW_ELEMENTS(MAX_ELEMS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    int unsigned row_len;
    logic [15:0] cur_scale;
    logic [15:0] cur_min;
    logic [7:0]  sub_bytes [12];
    int unsigned byte_pos;
    int unsigned blk_count;

    t_in_item  pending_bytes [$];
    t_out_item expected_pairs [$];
    int        send_idle;
    int        recv_idle;
    bit        byte_taken;
    int        stall_cycles;
    int        errors;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // value of p - b in fp32, both products exact in a 2^-24 fixed grid
    function automatic logic [31:0] dequant_value(input logic [15:0] hs,
            input logic [15:0] hm, input int unsigned sc, input int unsigned mn,
            input int unsigned q);
        logic        s_sign, m_sign, r_sign;
        logic [10:0] s_man, m_man;
        int unsigned s_sh, m_sh, e, shr, expo;
        longint      pm, bm, r;
        logic [63:0] mag, mant, rem, half;
        s_sign = hs[15] & (hs[14:0] != 0);
        m_sign = hm[15] & (hm[14:0] != 0);
        s_man = (hs[14:10] == 0) ? {1'b0, hs[9:0]} : {1'b1, hs[9:0]};
        m_man = (hm[14:10] == 0) ? {1'b0, hm[9:0]} : {1'b1, hm[9:0]};
        s_sh = (hs[14:10] == 0) ? 0 : hs[14:10] - 1;
        m_sh = (hm[14:10] == 0) ? 0 : hm[14:10] - 1;
        pm = (longint'(s_man) * sc * q) <<< s_sh;
        bm = (longint'(m_man) * mn) <<< m_sh;
        r = (s_sign ? -pm : pm) - (m_sign ? -bm : bm);
        if (r == 0) begin
            // only -0 minus +0 keeps a negative zero
            if (pm == 0 && bm == 0)
                return {s_sign & ~m_sign, 31'd0};
            return 32'd0;
        end
        r_sign = (r < 0);
        mag = r_sign ? -r : r;
        e = 0;
        for (int i = 0; i < 64; i++)
            if (mag[i]) e = i;
        expo = e + 103;
        if (e <= 23) begin
            mant = mag << (23 - e);
        end else begin
            shr = e - 23;
            mant = mag >> shr;
            rem = mag & ((64'd1 << shr) - 1);
            half = 64'd1 << (shr - 1);
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 1;
            if (mant == (64'd1 << 24)) begin
                mant = mant >> 1;
                expo = expo + 1;
            end
        end
        return {r_sign, expo[7:0], mant[22:0]};
    endfunction

    function automatic void sub_pair(input int unsigned j, output int unsigned sc,
            output int unsigned mn);
        if (j < 4) begin
            sc = sub_bytes[j] & 63;
            mn = sub_bytes[j+4] & 63;
        end else begin
            sc = (sub_bytes[j+4] & 4'hF) | ((sub_bytes[j-4] >> 6) << 4);
            mn = (sub_bytes[j+4] >> 4) | ((sub_bytes[j] >> 6) << 4);
        end
    endfunction

    task automatic dequant_byte(input t_in_item it);
        int unsigned len, nblocks, pos, k, g, l, blk, lo_idx, sc, mn;
        bit          last;
        t_out_item   res;
        if (it.row_begin) begin
            byte_pos = 0;
            blk_count = 0;
        end
        len = (row_len > MAX_ELEMS) ? MAX_ELEMS : row_len;
        nblocks = (len + 255) / 256;
        if (nblocks == 0) nblocks = 1;
        pos = byte_pos;
        if (pos >= BLOCK_BYTES - 1) begin
            last = (blk_count + 1 >= nblocks);
            byte_pos = 0;
            blk_count = last ? 0 : blk_count + 1;
        end else begin
            last = 0;
            byte_pos = pos + 1;
        end
        if (pos == 0) cur_scale[7:0] = it.data_byte;
        else if (pos == 1) cur_scale[15:8] = it.data_byte;
        else if (pos == 2) cur_min[7:0] = it.data_byte;
        else if (pos == 3) cur_min[15:8] = it.data_byte;
        else if (pos < HDR_BYTES) sub_bytes[pos-4] = it.data_byte;
        else begin
            k = pos - HDR_BYTES;
            g = (k >> 5) & 3;
            l = k & 31;
            blk = last ? nblocks - 1 : (pos >= BLOCK_BYTES - 1 ? blk_count - 1 : blk_count);
            lo_idx = blk * 256 + 64 * g + l;
            res.element_index = lo_idx[15:0];
            sub_pair(2 * g, sc, mn);
            res.low_value = dequant_value(cur_scale, cur_min, sc, mn, it.data_byte[3:0]);
            res.low_valid = (lo_idx < len);
            sub_pair(2 * g + 1, sc, mn);
            res.high_value = dequant_value(cur_scale, cur_min, sc, mn, it.data_byte[7:4]);
            res.high_valid = (lo_idx + 32 < len);
            res.row_last = last;
            expected_pairs.push_back(res);
        end
    endtask

    // sender side: take at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && i_push && !o_full;
        if (byte_taken)
            dequant_byte(i_in);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (i_push && !byte_taken) begin
            i_push <= 1'b1;
        end else if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
            i_push <= 1'b1;
            i_in <= pending_bytes.pop_front();
        end else begin
            i_push <= 1'b0;
        end
        i_pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // result side checker and stall watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_pairs.size() == 0) begin
                $error("result item with none expected: %h", o_out);
                errors++;
            end else begin
                want = expected_pairs.pop_front();
                if (o_out.element_index !== want.element_index) begin
                    $error("element_index exp %h got %h", want.element_index,
                           o_out.element_index);
                    errors++;
                end
                if (o_out.low_value !== want.low_value) begin
                    $error("low_value exp %h got %h", want.low_value, o_out.low_value);
                    errors++;
                end
                if (o_out.low_valid !== want.low_valid) begin
                    $error("low_valid exp %b got %b", want.low_valid, o_out.low_valid);
                    errors++;
                end
                if (o_out.high_value !== want.high_value) begin
                    $error("high_value exp %h got %h", want.high_value, o_out.high_value);
                    errors++;
                end
                if (o_out.high_valid !== want.high_valid) begin
                    $error("high_valid exp %b got %b", want.high_valid, o_out.high_valid);
                    errors++;
                end
                if (o_out.row_last !== want.row_last) begin
                    $error("row_last exp %b got %b", want.row_last, o_out.row_last);
                    errors++;
                end
            end
        end
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("q4k_block_dequantizer_test: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_half();
        logic [15:0] odd_halves [8] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF,
                                        16'h0001, 16'h83FF, 16'h7C00, 16'h3C00};
        if ($urandom_range(1)) return odd_halves[$urandom_range(7)];
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // one super-block; now and then a stray row start breaks it
    task automatic queue_block(input bit begin_row);
        t_in_item it;
        logic [15:0] sc, mn;
        int stray;
        sc = pick_half();
        mn = pick_half();
        stray = ($urandom_range(9) == 0) ? int'($urandom_range(1, 143)) : -1;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (i == 0) it.data_byte = sc[7:0];
            else if (i == 1) it.data_byte = sc[15:8];
            else if (i == 2) it.data_byte = mn[7:0];
            else if (i == 3) it.data_byte = mn[15:8];
            else it.data_byte = 8'($urandom_range(255));
            it.row_begin = (i == 0 && begin_row) || (i == stray);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || i_push || expected_pairs.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int unsigned lens [NUM_PHASES] = '{256, 1, 0, 65536, 131071, 512, 256, 300, 0};
        bit          begins [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};
        errors = 0;
        stall_cycles = 0;
        byte_taken = 0;
        send_idle = 31;
        recv_idle = 56;
        row_len = ROW_LEN_RESET;
        cur_scale = 0;
        cur_min = 0;
        byte_pos = 0;
        blk_count = 0;
        foreach (sub_bytes[i]) sub_bytes[i] = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        lens[NUM_PHASES-1] = $urandom_range(1, 700);
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            send_idle = (p < 3) ? 31 : (p < 6) ? 56 : 0;
            recv_idle = (p < 3) ? 56 : (p < 6) ? 31 : 0;
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_data = lens[p][CFG_W-1:0];
            row_len = lens[p];
            @(negedge i_clk);
            i_cfg_we = 1'b0;
            queue_block(begins[p]);
        end
        wait_drained();
        if (errors == 0)
            $display("q4k_block_dequantizer_test: PASS");
        else
            $display("q4k_block_dequantizer_test: FAIL");
        $finish;
    end

endmodule
